/* src/pctc_pkg.sv */
// ----------------------------------------------------------------------------
// pctc_pkg
// Shared types and constants of the per-channel interval time cache.
// ----------------------------------------------------------------------------
`default_nettype none

package pctc_pkg;

  localparam int ANTENNAS    = 64;
  localparam int MAX_ENTRIES = 32;

  localparam int ANT_W  = $clog2(ANTENNAS);
  localparam int POS_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = POS_W + 1;
  localparam int SLOT_W = ANT_W + POS_W;
  localparam int SLOTS  = ANTENNAS * MAX_ENTRIES;

  localparam int TIME_W = 54;
  localparam int HW_W   = 32;
  localparam int ROW_W  = 24;
  localparam int KEEP_W = 5;

  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(16);

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_FLUSH  = 2'd2,
    MODE_END    = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_HIT           = 4'd0,
    ST_NO_DATA       = 4'd1,
    ST_MISS_PRIOR    = 4'd2,
    ST_MISS_INTERNAL = 4'd3,
    ST_MISS_POST     = 4'd4,
    ST_ADDED         = 4'd5,
    ST_OUT_OF_ORDER  = 4'd6,
    ST_FLUSHED       = 4'd7,
    ST_END_NOTED     = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ANT,
    S_ADD_CHK,
    S_ADD_WR,
    S_SCAN,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    mode_t              mode;
    logic [ANT_W-1:0]   antenna_id;
    logic [TIME_W-1:0]  stamp;
    logic [HW_W-1:0]    half_width;
    logic [ROW_W-1:0]   row_index;
  } item_t;

  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [ROW_W-1:0]  hit_row;
  } result_t;

  typedef struct packed {
    logic [TIME_W-1:0] centre;
    logic [HW_W-1:0]   half_width;
    logic [ROW_W-1:0]  row;
  } entry_t;

  typedef struct packed {
    logic [TIME_W-1:0] first_seen;
    logic [POS_W-1:0]  head;
    logic [CNT_W-1:0]  count;
  } ant_rec_t;

endpackage

`default_nettype wire

/* src/pctc_if.sv */
// ----------------------------------------------------------------------------
// pctc_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface pctc_in_if;
  import pctc_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          mode;
  logic [ANT_W-1:0]    antenna_id;
  logic [TIME_W-1:0]   stamp;
  logic [HW_W-1:0]     half_width;
  logic [ROW_W-1:0]    row_index;
  modport source (output valid, mode, antenna_id, stamp, half_width, row_index,
                  input ready);
  modport sink (input valid, mode, antenna_id, stamp, half_width, row_index,
                output ready);
endinterface

interface pctc_out_if;
  import pctc_pkg::*;
  logic                valid;
  logic                ready;
  logic [3:0]          status;
  logic [ROW_W-1:0]    hit_row;
  modport source (output valid, status, hit_row, input ready);
  modport sink (input valid, status, hit_row, output ready);
endinterface

`default_nettype wire

/* src/pctc_ram.sv */
// ----------------------------------------------------------------------------
// pctc_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pctc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/pctc_seq.sv */
// ----------------------------------------------------------------------------
// pctc_seq
// Sequencer over the antenna record RAM and the entry RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module pctc_seq (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire pctc_pkg::item_t          item,
  input  wire logic [pctc_pkg::KEEP_W-1:0] keep,
  input  wire logic                     res_take,
  output logic                          ready,
  output pctc_pkg::result_t             res
);
  import pctc_pkg::*;

  seq_state_t          state_r, state_nxt;
  item_t               item_r;
  logic [POS_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [POS_W-1:0]    idx_r, idx_nxt;
  logic [TIME_W-1:0]   fst_r, fst_nxt;
  status_t             status_r, status_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [ANTENNAS-1:0] fsv_r;
  logic [ANTENNAS-1:0] lvalid_r;
  logic                end_r;

  logic                set_lvalid, set_fsv, flush_all, set_end;

  logic                ant_we;
  ant_rec_t            ant_wdata, ant_rdata;
  logic                ent_we;
  logic [SLOT_W-1:0]   ent_waddr, ent_raddr;
  entry_t              ent_wdata, ent_rdata;

  logic [POS_W-1:0]    cur_head;
  logic [CNT_W-1:0]    cur_cnt;
  logic [CNT_W-1:0]    keep_eff;
  logic [POS_W-1:0]    h2;
  logic [CNT_W-1:0]    c2;
  logic [TIME_W:0]     ent_end;
  logic [TIME_W:0]     t_plus_h;
  logic [CNT_W-1:0]    idx_inc;

  pctc_ram #(.WIDTH($bits(ant_rec_t)), .DEPTH(ANTENNAS)) u_ant_ram (
    .clk   (clk),
    .we    (ant_we),
    .waddr (item_r.antenna_id),
    .wdata (ant_wdata),
    .raddr (item.antenna_id),
    .rdata (ant_rdata)
  );

  pctc_ram #(.WIDTH($bits(entry_t)), .DEPTH(SLOTS)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  assign ready = (state_r == S_IDLE);

  // list head/count of an antenna read as zero until written after a flush
  assign cur_head = lvalid_r[item_r.antenna_id] ? ant_rdata.head  : '0;
  assign cur_cnt  = lvalid_r[item_r.antenna_id] ? ant_rdata.count : '0;
  assign keep_eff = ({1'b0, keep} > CNT_W'(MAX_ENTRIES - 1)) ?
                    CNT_W'(MAX_ENTRIES - 1) : CNT_W'(keep);
  assign ent_end  = {1'b0, ent_rdata.centre} + (TIME_W+1)'(ent_rdata.half_width);
  assign t_plus_h = {1'b0, item_r.stamp} + (TIME_W+1)'(ent_rdata.half_width);
  assign idx_inc  = {1'b0, idx_r} + CNT_W'(1);

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    fst_nxt    = fst_r;
    status_nxt = status_r;
    row_nxt    = row_r;
    set_lvalid = 1'b0;
    set_fsv    = 1'b0;
    flush_all  = 1'b0;
    set_end    = 1'b0;
    ant_we     = 1'b0;
    ant_wdata  = '{first_seen: fst_r, head: head_r, count: cnt_r};
    ent_we     = 1'b0;
    ent_waddr  = {item_r.antenna_id, POS_W'(head_r + cnt_r[POS_W-1:0])};
    ent_wdata  = '{centre: item_r.stamp, half_width: item_r.half_width,
                   row: item_r.row_index};
    ent_raddr  = {item_r.antenna_id, POS_W'(head_r + idx_r)};
    res        = '{valid: 1'b0, status: status_r, hit_row: row_r};
    h2         = cur_head;
    c2         = cur_cnt;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          row_nxt = '0;
          unique case (item.mode)
            MODE_FLUSH: begin
              flush_all  = 1'b1;
              status_nxt = ST_FLUSHED;
              state_nxt  = S_DONE;
            end
            MODE_END: begin
              set_end    = 1'b1;
              status_nxt = ST_END_NOTED;
              state_nxt  = S_DONE;
            end
            default: state_nxt = S_ANT;
          endcase
        end
      end

      S_ANT: begin
        fst_nxt = ant_rdata.first_seen;
        if (item_r.mode == MODE_ADD) begin
          // compact a full list down to its newest entries
          if (cur_cnt >= CNT_W'(MAX_ENTRIES)) begin
            h2 = POS_W'(cur_head + (cur_cnt - keep_eff));
            c2 = keep_eff;
          end
          head_nxt  = h2;
          cnt_nxt   = c2;
          ent_raddr = {item_r.antenna_id, POS_W'(h2 + c2[POS_W-1:0] - POS_W'(1))};
          state_nxt = (c2 != '0) ? S_ADD_CHK : S_ADD_WR;
        end else begin
          head_nxt  = cur_head;
          cnt_nxt   = cur_cnt;
          idx_nxt   = '0;
          ent_raddr = {item_r.antenna_id, cur_head};
          if (fsv_r[item_r.antenna_id] ? (item_r.stamp < ant_rdata.first_seen) : end_r)
          begin
            status_nxt = ST_NO_DATA;
            state_nxt  = S_DONE;
          end else if (cur_cnt == '0) begin
            status_nxt = ST_MISS_POST;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_ADD_CHK: begin
        if (item_r.stamp < ent_rdata.centre) begin
          // drop the word but keep the compaction
          ant_we     = 1'b1;
          set_lvalid = 1'b1;
          status_nxt = ST_OUT_OF_ORDER;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_ADD_WR;
        end
      end

      S_ADD_WR: begin
        ent_we     = 1'b1;
        ant_we     = 1'b1;
        ant_wdata  = '{first_seen: fsv_r[item_r.antenna_id] ? fst_r : item_r.stamp,
                       head: head_r, count: cnt_r + CNT_W'(1)};
        set_lvalid = 1'b1;
        set_fsv    = 1'b1;
        status_nxt = ST_ADDED;
        state_nxt  = S_DONE;
      end

      S_SCAN: begin
        if ({1'b0, item_r.stamp} <= ent_end) begin
          if (t_plus_h >= {1'b0, ent_rdata.centre}) begin
            status_nxt = ST_HIT;
            row_nxt    = ent_rdata.row;
          end else begin
            status_nxt = (idx_r == '0) ? ST_MISS_PRIOR : ST_MISS_INTERNAL;
          end
          state_nxt = S_DONE;
        end else if (idx_inc == cnt_r) begin
          status_nxt = ST_MISS_POST;
          state_nxt  = S_DONE;
        end else begin
          // advance to the next entry, one read per cycle
          idx_nxt   = idx_inc[POS_W-1:0];
          ent_raddr = {item_r.antenna_id, POS_W'(head_r + idx_inc[POS_W-1:0])};
        end
      end

      S_DONE: begin
        res.valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fsv_r    <= '0;
      lvalid_r <= '0;
      end_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (flush_all) begin
        lvalid_r <= '0;
      end else if (set_lvalid) begin
        lvalid_r[item_r.antenna_id] <= 1'b1;
      end
      if (set_fsv) begin
        fsv_r[item_r.antenna_id] <= 1'b1;
      end
      if (set_end) begin
        end_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      item_r <= item;
    end
    head_r   <= head_nxt;
    cnt_r    <= cnt_nxt;
    idx_r    <= idx_nxt;
    fst_r    <= fst_nxt;
    status_r <= status_nxt;
    row_r    <= row_nxt;
  end

endmodule

`default_nettype wire

/* src/per_channel_interval_time_cache_top.sv */
// ----------------------------------------------------------------------------
// per_channel_interval_time_cache_top
// Per-antenna cache of time-ordered intervals with add, lookup, flush, end.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake      payload
//   in_chan   in         valid/ready    mode, antenna_id, stamp, half_width,
//                                       row_index
//   out_chan  out        valid/ready    status, hit_row
//   cfg_*     in         cfg_we         cfg_wdata (keep_entries)
//
// One word at a time: the next word is taken only after the result of the
// last one is passed on. A lookup scans up to 32 entries one at a time, as
// set by the single read port of the entry RAM. The result word shows in the
// same cycle as the input is ready again.
// A finished result sits in the output register while the next word is
// taken. A stalled output holds the sequencer in its done step.
// Reset clears the list and first-seen valid bits and the end flag at once;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module per_channel_interval_time_cache_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  pctc_in_if.sink                          in_chan,
  pctc_out_if.source                       out_chan,
  input  wire logic                        cfg_we,
  input  wire logic [pctc_pkg::KEEP_W-1:0] cfg_wdata
);
  import pctc_pkg::*;

  logic [KEEP_W-1:0] keep_r;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [ROW_W-1:0]  out_row_r;

  logic              seq_ready;
  logic              start;
  logic              take;
  item_t             item;
  result_t           res;

  // pack the input word for the sequencer
  assign item = '{mode: mode_t'(in_chan.mode), antenna_id: in_chan.antenna_id,
                  stamp: in_chan.stamp, half_width: in_chan.half_width,
                  row_index: in_chan.row_index};

  assign in_chan.ready = seq_ready;
  assign start         = in_chan.valid && seq_ready;

  // load the output register when it is empty or being drained
  assign take = res.valid && (!out_valid_r || out_chan.ready);

  pctc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .item     (item),
    .keep     (keep_r),
    .res_take (take),
    .ready    (seq_ready),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r      <= KEEP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        keep_r <= cfg_wdata;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_status_r <= res.status;
      out_row_r    <= res.hit_row;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.status  = out_status_r;
  assign out_chan.hit_row = out_row_r;

endmodule

`default_nettype wire
